// ===== rtl/core/mmms_pkg.sv =====
// ----------------------------------------------------------------------------
// mmms_pkg: shared constants and types for the mean/median/mode core
// Field widths of the request and response words, default sizes and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
package mmms_pkg;

   // default configuration
   localparam int VALUE_BINS_DEF = 64;
   localparam int MAX_ITEMS_DEF  = 1024;

   // word field widths
   localparam int SAMPLE_W = 6;
   localparam int MEAN_W   = 14;
   localparam int MEDIAN_W = 7;
   localparam int VALUE_W  = 6;
   localparam int MCOUNT_W = 11;

   // fraction bits of the mean
   localparam int FRAC_W = 8;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_LD_RD   = 9'b000000010,
      ST_LD_WR   = 9'b000000100,
      ST_PREP    = 9'b000001000,
      ST_DIV     = 9'b000010000,
      ST_SCAN_RD = 9'b000100000,
      ST_SCAN_EV = 9'b001000000,
      ST_MODE_RD = 9'b010000000,
      ST_MODE_EV = 9'b100000000
   } state_type;

endpackage

// ===== rtl/core/mean_median_mode_stats_core.sv =====
// ----------------------------------------------------------------------------
// mean_median_mode_stats_core: histogram mean, median and mode
// Loads samples into a bin histogram, then on end of set computes the
// mean by restoring division, walks the bins for median and peak count,
// and walks them again to report every mode in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_sample, req_end_of_set) are taken on a clock edge
//   where start is high and busy is low. A sample occupies the block for
//   accept, bin read and bin write, one read-modify-write of its bin.
//   A sample beyond the bins saturates to the top bin; once MAX_ITEMS
//   samples are held, further samples are dropped (no busy time) but an
//   end-of-set word still closes the set.
//   Closing a set keeps the block busy for a setup step, then restoring
//   division for the mean at one quotient bit per cycle (DIV_W = sum
//   width + 8, 24 at the defaults), then two walks over the bins, each
//   bin read and then evaluated through the single memory read port; the
//   top bin is evaluated once more when it is a mode after another mode.
//   Response words appear with rsp_valid high for one cycle each, one per
//   mode during the second walk; the final one (rsp_last_result) comes from
//   the last bin evaluation, and busy drops in the same cycle it appears.
//   The receiver cannot stall; words are never held.
//   Reset clears the sequencer, sum, count and the bin valid bits, so the
//   histogram reads as all zero without a clearing pass; the same happens
//   at the close of every set.
// ----------------------------------------------------------------------------
module mean_median_mode_stats_core
   import mmms_pkg::*;
#(
   parameter int VALUE_BINS = VALUE_BINS_DEF,
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_end_of_set,
   // response channel
   output logic                rsp_valid,
   output logic [MEAN_W-1:0]   rsp_mean_q8,
   output logic [MEDIAN_W-1:0] rsp_median_x2,
   output logic                rsp_has_mode,
   output logic [VALUE_W-1:0]  rsp_mode_value,
   output logic [MCOUNT_W-1:0] rsp_mode_count,
   output logic                rsp_last_result
);

   localparam int BIN_AW = $clog2(VALUE_BINS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W  = $clog2(MAX_ITEMS * (VALUE_BINS - 1) + 1);
   localparam int DIV_W  = SUM_W + FRAC_W;
   localparam int IT_W   = $clog2(DIV_W + 1);

   // state
   state_type               state_ff, state_in;
   logic [BIN_AW-1:0]       samp_ff, samp_in;
   logic                    last_ff, last_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [VALUE_BINS-1:0]   vld_ff, vld_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [IT_W-1:0]         iter_ff, iter_in;
   logic [BIN_AW-1:0]       addr_ff, addr_in;
   logic [CNT_W:0]          cum_ff, cum_in;
   logic                    lo_ok_ff, lo_ok_in;
   logic                    hi_ok_ff, hi_ok_in;
   logic [BIN_AW-1:0]       vlo_ff, vlo_in;
   logic [BIN_AW-1:0]       vhi_ff, vhi_in;
   logic [CNT_W-1:0]        maxc_ff, maxc_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [BIN_AW-1:0]       pend_val_ff, pend_val_in;

   // histogram memory
   logic [CNT_W-1:0]        mem_ff [VALUE_BINS];
   logic [CNT_W-1:0]        rd_raw_ff;
   logic                    rd_ok_ff;
   logic [BIN_AW-1:0]       rd_addr;
   logic                    wr_en;
   logic [CNT_W-1:0]        bin_cnt;

   // response registers
   logic                    rsp_valid_ff;
   logic [MEAN_W-1:0]       rsp_mean_ff;
   logic [MEDIAN_W-1:0]     rsp_median_ff;
   logic                    rsp_has_ff;
   logic [VALUE_W-1:0]      rsp_value_ff;
   logic [MCOUNT_W-1:0]     rsp_count_ff;
   logic                    rsp_last_ff;

   // emit request from the sequencer
   logic                    emit;
   logic                    emit_has;
   logic [BIN_AW-1:0]       emit_val;
   logic                    emit_last;

   // helpers
   logic                    accept;
   logic                    full;
   logic                    samp_big;
   logic [BIN_AW-1:0]       samp_sat;
   logic [CNT_W-1:0]        rank_lo, rank_hi;
   logic [CNT_W:0]          cum_nx;
   logic [CNT_W:0]          rem_sh;
   logic                    div_ge;
   logic                    last_bin;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign full     = (cnt_ff == CNT_W'(MAX_ITEMS));
   assign samp_big = ({1'b0, req_sample} >= (SAMPLE_W + 1)'(VALUE_BINS));
   assign samp_sat = samp_big ? BIN_AW'(VALUE_BINS - 1) : BIN_AW'(req_sample);

   // median ranks: equal for odd count
   assign rank_lo  = (cnt_ff - CNT_W'(1)) >> 1;
   assign rank_hi  = cnt_ff >> 1;

   assign bin_cnt  = rd_ok_ff ? rd_raw_ff : '0;
   assign cum_nx   = cum_ff + (CNT_W + 1)'(bin_cnt);
   assign last_bin = (addr_ff == BIN_AW'(VALUE_BINS - 1));

   // restoring divider step
   assign rem_sh   = {rem_ff, div_ff[DIV_W-1]};
   assign div_ge   = (rem_sh >= {1'b0, cnt_ff});

   assign rd_addr  = (state_ff == ST_LD_RD) ? samp_ff : addr_ff;
   assign wr_en    = (state_ff == ST_LD_WR);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      samp_in     = samp_ff;
      last_in     = last_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      vld_in      = vld_ff;
      div_in      = div_ff;
      rem_in      = rem_ff;
      iter_in     = iter_ff;
      addr_in     = addr_ff;
      cum_in      = cum_ff;
      lo_ok_in    = lo_ok_ff;
      hi_ok_in    = hi_ok_ff;
      vlo_in      = vlo_ff;
      vhi_in      = vhi_ff;
      maxc_in     = maxc_ff;
      pend_vld_in = pend_vld_ff;
      pend_val_in = pend_val_ff;
      emit        = 1'b0;
      emit_has    = 1'b0;
      emit_val    = '0;
      emit_last   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_end_of_set;
               if (!full) begin
                  samp_in  = samp_sat;
                  sum_in   = sum_ff + SUM_W'(samp_sat);
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = ST_LD_RD;
               end else if (req_end_of_set) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_LD_RD: begin
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            vld_in[samp_ff] = 1'b1;
            state_in = last_ff ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            div_in   = {sum_ff, FRAC_W'(0)};
            rem_in   = '0;
            iter_in  = IT_W'(DIV_W);
            addr_in  = '0;
            cum_in   = '0;
            lo_ok_in = 1'b0;
            hi_ok_in = 1'b0;
            vlo_in   = '0;
            vhi_in   = '0;
            maxc_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_ge ? CNT_W'(rem_sh - {1'b0, cnt_ff}) : CNT_W'(rem_sh);
            div_in  = {div_ff[DIV_W-2:0], div_ge};
            iter_in = iter_ff - IT_W'(1);
            if (iter_ff == IT_W'(1)) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            // cumulative count locates both median ranks; track peak count
            cum_in = cum_nx;
            if (!lo_ok_ff && (cum_nx > (CNT_W + 1)'(rank_lo))) begin
               lo_ok_in = 1'b1;
               vlo_in   = addr_ff;
            end
            if (!hi_ok_ff && (cum_nx > (CNT_W + 1)'(rank_hi))) begin
               hi_ok_in = 1'b1;
               vhi_in   = addr_ff;
            end
            if (bin_cnt > maxc_ff) begin
               maxc_in = bin_cnt;
            end
            if (last_bin) begin
               addr_in     = '0;
               pend_vld_in = 1'b0;
               state_in    = ST_MODE_RD;
            end else begin
               addr_in  = addr_ff + BIN_AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_MODE_RD: begin
            state_in = ST_MODE_EV;
         end
         ST_MODE_EV: begin
            // one mode held back so the final one can carry the last flag
            if ((maxc_ff > CNT_W'(1)) && (bin_cnt == maxc_ff)) begin
               if (pend_vld_ff) begin
                  emit     = 1'b1;
                  emit_has = 1'b1;
                  emit_val = pend_val_ff;
               end
               pend_vld_in = 1'b1;
               pend_val_in = addr_ff;
            end
            if (last_bin) begin
               // close the set: final word, then clear the histogram
               emit      = 1'b1;
               emit_last = 1'b1;
               if ((maxc_ff > CNT_W'(1)) && (bin_cnt == maxc_ff)) begin
                  if (pend_vld_ff) begin
                     // both a held mode and this bin: emit held, keep this
                     emit_last = 1'b0;
                     emit_has  = 1'b1;
                     emit_val  = pend_val_ff;
                     state_in  = ST_MODE_EV;
                     addr_in   = addr_ff;
                  end else begin
                     emit_has = 1'b1;
                     emit_val = addr_ff;
                  end
               end else begin
                  emit_has = pend_vld_ff;
                  emit_val = pend_vld_ff ? pend_val_ff : '0;
               end
               if (emit_last) begin
                  vld_in      = '0;
                  sum_in      = '0;
                  cnt_in      = '0;
                  pend_vld_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  // revisit the top bin once more as the final mode
                  pend_vld_in = 1'b0;
               end
            end else begin
               addr_in  = addr_ff + BIN_AW'(1);
               state_in = ST_MODE_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= emit;
         pend_vld_ff  <= pend_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      samp_ff     <= samp_in;
      last_ff     <= last_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      iter_ff     <= iter_in;
      addr_ff     <= addr_in;
      cum_ff      <= cum_in;
      lo_ok_ff    <= lo_ok_in;
      hi_ok_ff    <= hi_ok_in;
      vlo_ff      <= vlo_in;
      vhi_ff      <= vhi_in;
      maxc_ff     <= maxc_in;
      pend_val_ff <= pend_val_in;
   end

   // histogram memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[samp_ff] <= bin_cnt + CNT_W'(1);
      end
      rd_raw_ff <= mem_ff[rd_addr];
      rd_ok_ff  <= vld_ff[rd_addr];
   end

   // response word
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_mean_ff   <= MEAN_W'(div_ff);
         rsp_median_ff <= MEDIAN_W'((BIN_AW + 1)'(vlo_ff) + (BIN_AW + 1)'(vhi_ff));
         rsp_has_ff    <= emit_has;
         rsp_value_ff  <= VALUE_W'(emit_val);
         rsp_count_ff  <= emit_has ? MCOUNT_W'(maxc_ff) : '0;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_q8     = rsp_mean_ff;
   assign rsp_median_x2   = rsp_median_ff;
   assign rsp_has_mode    = rsp_has_ff;
   assign rsp_mode_value  = rsp_value_ff;
   assign rsp_mode_count  = rsp_count_ff;
   assign rsp_last_result = rsp_last_ff;

   // checks
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> (cnt_ff == '0) && (sum_ff == '0) && !busy)
      else $error("set state not cleared at final word");

   a_mid_is_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> rsp_has_mode)
      else $error("non-final word without a mode");

   a_div_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff != '0))
      else $error("division on an empty set");

   a_mode_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_mode |-> (rsp_mode_count > MCOUNT_W'(1)) || (CNT_W > MCOUNT_W))
      else $error("mode word with count of one or less");

endmodule

// ===== verif/mean_median_mode_stats_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mean_median_mode_stats_core_checker: stats prediction and response check
// Watches the request and response channels of the core. Every accepted
// request word is loaded into a private histogram. On the closing word the
// mean, median and mode words are predicted and queued. Each response word
// is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module mean_median_mode_stats_core_checker
   import mmms_pkg::*;
#(
   parameter int VALUE_BINS = VALUE_BINS_DEF,
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   input  logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_end_of_set,
   // response channel
   input  logic                rsp_valid,
   input  logic [MEAN_W-1:0]   rsp_mean_q8,
   input  logic [MEDIAN_W-1:0] rsp_median_x2,
   input  logic                rsp_has_mode,
   input  logic [VALUE_W-1:0]  rsp_mode_value,
   input  logic [MCOUNT_W-1:0] rsp_mode_count,
   input  logic                rsp_last_result,
   // status for the testbench top
   output int                  err_count,
   output int                  due_count,
   output int                  sets_done,
   output int                  words_seen,
   output int                  nomode_sets,
   output int                  widest_tie
);

   typedef struct packed {
      logic [MEAN_W-1:0]   mean_q8;
      logic [MEDIAN_W-1:0] median_x2;
      logic                has_mode;
      logic [VALUE_W-1:0]  mode_value;
      logic [MCOUNT_W-1:0] mode_count;
      logic                last_result;
   } stats_word_type;

   // private copy of the histogram state
   int unsigned bin_tally [VALUE_BINS];
   int unsigned sum_acc;
   int unsigned held_count;

   // stats words still owed by the core
   stats_word_type stats_due [$];

   int err_total;
   int set_total;
   int word_total;
   int nomode_total;
   int tie_max;

   // sorted-order value at a 0-based rank
   function automatic int unsigned rank_value(input int unsigned rank);
      int unsigned cum;
      cum = 0;
      for (int v = 0; v < VALUE_BINS; v++) begin
         cum += bin_tally[v];
         if (cum > rank) return v;
      end
      return VALUE_BINS - 1;
   endfunction

   task automatic clear_histogram();
      for (int v = 0; v < VALUE_BINS; v++) bin_tally[v] = 0;
      sum_acc    = 0;
      held_count = 0;
   endtask

   // load one request word; the closing word queues the set's stats words
   task automatic load_word(input logic [SAMPLE_W-1:0] value, input logic closing);
      int unsigned    bin_idx;
      int unsigned    mean_full;
      int unsigned    med2;
      int unsigned    peak;
      int             ties;
      int             emitted;
      stats_word_type w;
      bin_idx = 32'(value);
      if (bin_idx >= VALUE_BINS) bin_idx = VALUE_BINS - 1;
      // count full: the word is dropped, but may still close the set
      if (held_count < MAX_ITEMS) begin
         bin_tally[bin_idx]++;
         sum_acc += bin_idx;
         held_count++;
      end
      if (!closing) return;

      mean_full = (sum_acc * 256) / held_count;
      if (held_count % 2 != 0)
         med2 = 2 * rank_value(held_count / 2);
      else
         med2 = rank_value(held_count / 2 - 1) + rank_value(held_count / 2);

      peak = 0;
      ties = 0;
      for (int v = 0; v < VALUE_BINS; v++)
         if (bin_tally[v] > peak) peak = bin_tally[v];
      for (int v = 0; v < VALUE_BINS; v++)
         if (bin_tally[v] == peak) ties++;

      w           = '0;
      w.mean_q8   = MEAN_W'(mean_full);
      w.median_x2 = MEDIAN_W'(med2);
      if (peak > 1) begin
         // one word per mode, ascending value
         emitted = 0;
         for (int v = 0; v < VALUE_BINS; v++) begin
            if (bin_tally[v] == peak) begin
               emitted++;
               w.has_mode    = 1'b1;
               w.mode_value  = VALUE_W'(v);
               w.mode_count  = MCOUNT_W'(peak);
               w.last_result = (emitted == ties);
               stats_due     = {stats_due, w};
            end
         end
         if (ties > tie_max) tie_max = ties;
      end else begin
         // no value repeats: a single word without a mode
         w.last_result = 1'b1;
         stats_due     = {stats_due, w};
         nomode_total++;
      end
      set_total++;
      clear_histogram();
   endtask

   // monitor both channels on the edge that accepts them
   always @(posedge clock) begin
      stats_word_type got;
      stats_word_type want;
      if (reset) begin
         clear_histogram();
         stats_due.delete();
         err_total    = 0;
         set_total    = 0;
         word_total   = 0;
         nomode_total = 0;
         tie_max      = 0;
      end else begin
         // response word against the oldest expectation
         if (rsp_valid) begin
            got.mean_q8     = rsp_mean_q8;
            got.median_x2   = rsp_median_x2;
            got.has_mode    = rsp_has_mode;
            got.mode_value  = rsp_mode_value;
            got.mode_count  = rsp_mode_count;
            got.last_result = rsp_last_result;
            word_total++;
            if (stats_due.size() == 0) begin
               err_total++;
               if (err_total <= 10)
                  $display({"ERROR: unexpected stats word ",
                            "mean=%0d med2=%0d mode=%0b v=%0d n=%0d last=%0b"},
                     got.mean_q8, got.median_x2, got.has_mode, got.mode_value,
                     got.mode_count, got.last_result);
            end else begin
               want = stats_due.pop_front();
               if (got.mean_q8 !== want.mean_q8 || got.median_x2 !== want.median_x2 ||
                   got.has_mode !== want.has_mode || got.mode_value !== want.mode_value ||
                   got.mode_count !== want.mode_count ||
                   got.last_result !== want.last_result) begin
                  err_total++;
                  if (err_total <= 10) begin
                     $display("ERROR: stats word %0d of set %0d differs", word_total,
                        set_total);
                     $display("   expected mean=%0d med2=%0d mode=%0b v=%0d n=%0d last=%0b",
                        want.mean_q8, want.median_x2, want.has_mode, want.mode_value,
                        want.mode_count, want.last_result);
                     $display("   actual   mean=%0d med2=%0d mode=%0b v=%0d n=%0d last=%0b",
                        got.mean_q8, got.median_x2, got.has_mode, got.mode_value,
                        got.mode_count, got.last_result);
                  end
               end
            end
         end
         // request word
         if (start && !busy) load_word(req_sample, req_end_of_set);
      end
      err_count   <= err_total;
      due_count   <= stats_due.size();
      sets_done   <= set_total;
      words_seen  <= word_total;
      nomode_sets <= nomode_total;
      widest_tie  <= tie_max;
   end

endmodule

// ===== verif/mean_median_mode_stats_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mean_median_mode_stats_core_tb: testbench for the histogram stats core
// Drives request words as sets of samples: a directed batch of small sets,
// a set with every value tied, then random sets of varied length and
// value spread with random idle bursts.
// A checker beside the core predicts and compares every response word.
// ----------------------------------------------------------------------------
module mean_median_mode_stats_core_tb
   import mmms_pkg::*;
;

   localparam int BINS         = VALUE_BINS_DEF;
   localparam int ITEM_CAP     = MAX_ITEMS_DEF;
   localparam int RAND_ITEMS   = 310;
   // drain time, longer than the core stays busy closing a set
   localparam int DRAIN_CYCLES = 320;
   // several times the longest quiet stretch of a correct run
   localparam int STALL_LIMIT  = 2000;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic [SAMPLE_W-1:0] req_sample     = '0;
   logic                req_end_of_set = 1'b0;
   logic                busy;
   logic                rsp_valid;
   logic [MEAN_W-1:0]   rsp_mean_q8;
   logic [MEDIAN_W-1:0] rsp_median_x2;
   logic                rsp_has_mode;
   logic [VALUE_W-1:0]  rsp_mode_value;
   logic [MCOUNT_W-1:0] rsp_mode_count;
   logic                rsp_last_result;

   int err_count;
   int due_count;
   int sets_done;
   int words_seen;
   int nomode_sets;
   int widest_tie;

   bit idle_on = 1'b1;
   int stall_cycles = 0;

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   mean_median_mode_stats_core #(
      .VALUE_BINS (BINS),
      .MAX_ITEMS  (ITEM_CAP)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample      (req_sample),
      .req_end_of_set  (req_end_of_set),
      .rsp_valid       (rsp_valid),
      .rsp_mean_q8     (rsp_mean_q8),
      .rsp_median_x2   (rsp_median_x2),
      .rsp_has_mode    (rsp_has_mode),
      .rsp_mode_value  (rsp_mode_value),
      .rsp_mode_count  (rsp_mode_count),
      .rsp_last_result (rsp_last_result)
   );

   mean_median_mode_stats_core_checker #(
      .VALUE_BINS (BINS),
      .MAX_ITEMS  (ITEM_CAP)
   ) stats_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample      (req_sample),
      .req_end_of_set  (req_end_of_set),
      .rsp_valid       (rsp_valid),
      .rsp_mean_q8     (rsp_mean_q8),
      .rsp_median_x2   (rsp_median_x2),
      .rsp_has_mode    (rsp_has_mode),
      .rsp_mode_value  (rsp_mode_value),
      .rsp_mode_count  (rsp_mode_count),
      .rsp_last_result (rsp_last_result),
      .err_count       (err_count),
      .due_count       (due_count),
      .sets_done       (sets_done),
      .words_seen      (words_seen),
      .nomode_sets     (nomode_sets),
      .widest_tie      (widest_tie)
   );

   // watchdog: quiet cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // present one request word, with an optional idle burst first,
   // and return on the edge that accepts it
   task automatic send_word(input logic [SAMPLE_W-1:0] value, input logic closing);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_sample     <= value;
      req_end_of_set <= closing;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int                  items_loaded;
      int                  set_len;
      int                  style;
      int                  base;
      int                  pick;
      logic [SAMPLE_W-1:0] val;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: single-word sets at both extremes, no mode
      send_word(6'd0, 1'b1);
      send_word(6'd63, 1'b1);
      // pair: even median, one mode
      send_word(6'd5, 1'b0);
      send_word(6'd5, 1'b1);
      // distinct values: no mode, odd count
      send_word(6'd0, 1'b0);
      send_word(6'd63, 1'b0);
      send_word(6'd10, 1'b1);
      // three-way tie, unsorted arrival
      send_word(6'd3, 1'b0);
      send_word(6'd1, 1'b0);
      send_word(6'd3, 1'b0);
      send_word(6'd1, 1'b0);
      send_word(6'd62, 1'b0);
      send_word(6'd62, 1'b0);
      send_word(6'd7, 1'b1);
      // fractional mean
      send_word(6'd0, 1'b0);
      send_word(6'd1, 1'b0);
      send_word(6'd1, 1'b1);
      // lopsided set, top value repeats but loses to a higher count
      send_word(6'd63, 1'b0);
      send_word(6'd63, 1'b0);
      send_word(6'd0, 1'b0);
      send_word(6'd0, 1'b0);
      send_word(6'd0, 1'b0);
      send_word(6'd42, 1'b1);

      // every value twice: a mode word for each value
      for (int v = BINS - 1; v >= 0; v--) begin
         send_word(SAMPLE_W'(v), 1'b0);
         send_word(SAMPLE_W'(v), v == 0);
      end

      // random sets: mostly short, narrow spreads for frequent ties
      items_loaded = 0;
      while (items_loaded < RAND_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5)
            set_len = $urandom_range(1, 8);
         else if (pick <= 8)
            set_len = $urandom_range(9, 24);
         else
            set_len = $urandom_range(25, 70);
         style   = $urandom_range(0, 3);
         base    = $urandom_range(0, 60);
         // final stretch runs without idle bursts
         idle_on = (items_loaded < RAND_ITEMS - 80) && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < set_len; i++) begin
            case (style)
               0: val = SAMPLE_W'($urandom_range(0, 63));
               1: val = SAMPLE_W'(base + $urandom_range(0, 3));
               2: val = $urandom_range(0, 1) ? 6'd63 : 6'd0;
               default: val = SAMPLE_W'(base + $urandom_range(0, 1));
            endcase
            send_word(val, i == set_len - 1);
            items_loaded++;
         end
      end
      start <= 1'b0;

      // drain: wait for every owed stats word, then a full close time
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d sets and %0d stats words: %0d without a mode, %s %0d.",
         sets_done, words_seen, nomode_sets, "widest tie", widest_tie);
      $display("Included single-word sets, a tie across every value and idle bursts.");
      if (err_count == 0 && due_count == 0) begin
         $display("== PASS ==");
      end else begin
         if (due_count != 0) $display("ERROR: %0d stats words never arrived", due_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
